// ===== rtl/dd_pkg.sv =====
package dd_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 23;
    localparam int DIST_W   = 22;
    localparam int DOY_W    = 9;
    localparam int LEAPS_W  = 13;

    // Saturation value of the day distance
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Reciprocal of 25 as 5243 / 2^17, exact floor for dividends below 4121
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;

    // Cycles from start to the result strobe
    localparam int LATENCY = 5;

    // Epoch 1970-01-01 was a Thursday (3 with Monday as 0)
    localparam int EPOCH_YEAR    = 1970;
    localparam int EPOCH_WEEKDAY = 3;
    localparam int EPOCH_SERIAL  = EPOCH_YEAR * 365 + (EPOCH_YEAR + 3) / 4
                                 - (EPOCH_YEAR + 99) / 100 + (EPOCH_YEAR + 399) / 400 + 1;
    // Weekday = (serial mod 7 + WD_OFFSET) mod 7
    localparam int WD_OFFSET     = (7 - EPOCH_SERIAL % 7 + EPOCH_WEEKDAY) % 7;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] day_distance;
        logic [2:0]        weekday;
        logic              month_error;
    } t_out;

    // Control that travels alongside the data
    typedef struct packed {
        logic valid;
        logic month_error;
    } t_ctl;

    function automatic logic month_bad(input logic [MONTH_W-1:0] m);
        month_bad = (m == '0) || (m > 4'd12);
    endfunction

    // Days in the months before month m of a common year
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] v;
        unique case (m)
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        cum_days = v;
    endfunction

endpackage

// ===== rtl/dd_serial.sv =====
module dd_serial (
    input  logic                         i_clk,
    input  logic [dd_pkg::YEAR_W-1:0]    i_year,
    input  logic [dd_pkg::MONTH_W-1:0]   i_month,
    input  logic [dd_pkg::DAY_W-1:0]     i_day,
    output logic [dd_pkg::SERIAL_W-1:0]  o_serial
);

    // ---- stage A: century and 400-year quotients by reciprocal ----
    logic [14:0] sum_b, sum_c;
    logic [12:0] div_b;
    logic [10:0] div_c;
    logic [25:0] prod_b;
    logic [23:0] prod_c;

    logic [dd_pkg::YEAR_W-1:0]  r_a_year;
    logic [dd_pkg::MONTH_W-1:0] r_a_month;
    logic [dd_pkg::DAY_W-1:0]   r_a_day;
    logic [7:0]                 r_q100, n_q100;
    logic [5:0]                 r_q400, n_q400;

    always_comb begin
        sum_b  = {1'b0, i_year} + 15'd99;
        sum_c  = {1'b0, i_year} + 15'd399;
        div_b  = sum_b[14:2];
        div_c  = sum_c[14:4];
        prod_b = 26'(div_b) * 26'(dd_pkg::RECIP_25);
        prod_c = 24'(div_c) * 24'(dd_pkg::RECIP_25);
        n_q100 = prod_b[dd_pkg::RECIP_SHIFT +: 8];
        n_q400 = prod_c[dd_pkg::RECIP_SHIFT +: 6];
    end

    always_ff @(posedge i_clk) begin
        r_a_year  <= i_year;
        r_a_month <= i_month;
        r_a_day   <= i_day;
        r_q100    <= n_q100;
        r_q400    <= n_q400;
    end

    // ---- stage B: leap count, leap flag, year days, day of year ----
    logic [14:0]                 sum_a;
    logic                        is_leap;
    logic [dd_pkg::SERIAL_W-1:0] n_yd, r_yd;
    logic [dd_pkg::LEAPS_W-1:0]  n_leaps, r_leaps;
    logic [dd_pkg::DOY_W-1:0]    n_doy, r_doy;

    always_comb begin
        sum_a   = {1'b0, r_a_year} + 15'd3;
        n_leaps = sum_a[14:2] - 13'(r_q100) + 13'(r_q400);
        // divisible by 100 iff ceil(y/100)*100 == y, same for 400
        is_leap = (r_a_year[1:0] == 2'b00) &&
                  ((15'(r_q100) * 15'd100 != {1'b0, r_a_year}) ||
                   (15'(r_q400) * 15'd400 == {1'b0, r_a_year}));
        n_yd    = dd_pkg::SERIAL_W'(r_a_year) * dd_pkg::SERIAL_W'(365);
        n_doy   = dd_pkg::cum_days(r_a_month) + dd_pkg::DOY_W'(r_a_day)
                + dd_pkg::DOY_W'(is_leap && (r_a_month > 4'd2));
    end

    always_ff @(posedge i_clk) begin
        r_yd    <= n_yd;
        r_leaps <= n_leaps;
        r_doy   <= n_doy;
    end

    // ---- stage C: day serial ----
    logic [dd_pkg::SERIAL_W-1:0] r_serial, n_serial;

    assign n_serial = r_yd + dd_pkg::SERIAL_W'(r_leaps) + dd_pkg::SERIAL_W'(r_doy);

    always_ff @(posedge i_clk) begin
        r_serial <= n_serial;
    end

    assign o_serial = r_serial;

endmodule

// ===== rtl/dd_finish.sv =====
module dd_finish (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dd_pkg::t_ctl                 i_ctl,
    input  logic [dd_pkg::SERIAL_W-1:0]  i_serial_first,
    input  logic [dd_pkg::SERIAL_W-1:0]  i_serial_second,
    output logic                         o_valid,
    output dd_pkg::t_out                 o_result
);

    // ---- stage D: absolute difference, first mod-7 fold (8 == 1 mod 7) ----
    logic [dd_pkg::SERIAL_W-1:0] diff;
    logic [23:0]                 padded;
    logic [5:0]                  fold;
    logic [dd_pkg::DIST_W-1:0]   n_dist, r_dist;
    logic [5:0]                  r_fold;
    dd_pkg::t_ctl                r_d_ctl;

    always_comb begin
        if (i_serial_first >= i_serial_second) begin
            diff = i_serial_first - i_serial_second;
        end else begin
            diff = i_serial_second - i_serial_first;
        end
        n_dist = diff[dd_pkg::SERIAL_W-1] ? dd_pkg::DIST_MAX : diff[dd_pkg::DIST_W-1:0];
        padded = {1'b0, i_serial_first};
        fold   = '0;
        for (int k = 0; k < 8; k++) begin
            fold = fold + 6'(padded[3*k +: 3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else begin
            r_d_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_fold <= fold;
    end

    // ---- stage E: final fold, weekday, output register ----
    logic [3:0]   rem_sum, rem7, wd_sum;
    logic [2:0]   wd;
    logic         r_valid;
    dd_pkg::t_out r_result, n_result;

    always_comb begin
        rem_sum = 4'(r_fold[5:3]) + 4'(r_fold[2:0]);
        if (rem_sum >= 4'd14) begin
            rem7 = rem_sum - 4'd14;
        end else if (rem_sum >= 4'd7) begin
            rem7 = rem_sum - 4'd7;
        end else begin
            rem7 = rem_sum;
        end
        wd_sum = rem7 + 4'(dd_pkg::WD_OFFSET);
        wd     = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

        if (r_d_ctl.month_error) begin
            n_result = '{day_distance: '0, weekday: '0, month_error: 1'b1};
        end else begin
            n_result = '{day_distance: r_dist, weekday: wd, month_error: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/date_difference_and_weekday_unit.sv =====
// Channel   Transfer on                Payload
// --------  -------------------------  ------------------------------
// command   start && !busy             i_item   (dd_pkg::t_in)
// result    o_valid                    o_result (dd_pkg::t_out)
//
// Three stages build each date's day serial (reciprocal quotients, leap
// count and year-days product, final sum), two stages form the distance
// and the weekday. One command per cycle; busy stays low because the
// pipeline never holds. Synchronous reset clears the control pipeline
// registers only. Results appear for one cycle and cannot be held off.
module date_difference_and_weekday_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  dd_pkg::t_in   i_item,
    output logic          o_valid,
    output dd_pkg::t_out  o_result
);

    logic                        accept;
    dd_pkg::t_ctl                in_ctl;
    dd_pkg::t_ctl                r_ctl [3];
    logic [dd_pkg::SERIAL_W-1:0] serial_first, serial_second;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        in_ctl.valid       = accept;
        in_ctl.month_error = dd_pkg::month_bad(i_item.first_month) ||
                             dd_pkg::month_bad(i_item.second_month);
    end

    // Control pipeline matching the serial stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
            r_ctl[1] <= '0;
            r_ctl[2] <= '0;
        end else begin
            r_ctl[0] <= in_ctl;
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= r_ctl[1];
        end
    end

    dd_serial u_serial_first (
        .i_clk    (i_clk),
        .i_year   (i_item.first_year),
        .i_month  (i_item.first_month),
        .i_day    (i_item.first_day),
        .o_serial (serial_first)
    );

    dd_serial u_serial_second (
        .i_clk    (i_clk),
        .i_year   (i_item.second_year),
        .i_month  (i_item.second_month),
        .i_day    (i_item.second_day),
        .o_serial (serial_second)
    );

    dd_finish u_finish (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (r_ctl[2]),
        .i_serial_first  (serial_first),
        .i_serial_second (serial_second),
        .o_valid         (o_valid),
        .o_result        (o_result)
    );

endmodule

// ===== rtl/dd_checker.sv =====
module dd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input dd_pkg::t_out o_result,
    input logic         o_valid
);

    // Every transfer in yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(dd_pkg::LATENCY) o_valid)
        else $error("result missing after command transfer");

    // No result without a command transfer at the matching cycle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, dd_pkg::LATENCY))
        else $error("result without command transfer");

    // Month error clears the other fields
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.month_error) |->
            (o_result.day_distance == '0) && (o_result.weekday == '0))
        else $error("month error with nonzero fields");

    // Weekday stays within Monday..Sunday
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.weekday <= 3'd6))
        else $error("weekday out of range");

endmodule

bind date_difference_and_weekday_unit dd_checker u_dd_checker (.*);

// ===== bench/date_span_checker.sv =====
`timescale 1ns / 100ps

// Watches the command and result channels, predicts each result from the
// accepted dates and compares it with what the unit returns.
module date_span_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  logic         busy,
    input  dd_pkg::t_in  i_item,
    input  logic         o_valid,
    input  dd_pkg::t_out o_result,
    output int unsigned  o_fail_count,
    output int unsigned  o_pending
);

    localparam longint SPAN_CEILING = 4194303;
    localparam longint EPOCH_Y      = 1970;
    localparam longint THURSDAY     = 3;

    // Days before each month of a common year, indexed by month
    int month_offset [0:12] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    dd_pkg::t_out awaited_results [$];
    dd_pkg::t_out oldest;
    int unsigned  fails = 0;

    function automatic bit leap(input longint y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic bit month_ok(input logic [3:0] m);
        return (m >= 4'd1) && (m <= 4'd12);
    endfunction

    // Day count since the start of year 0, which is treated as a leap year
    function automatic longint day_number(input longint y, input longint m, input longint d);
        longint leaps;
        leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        day_number = y * 365 + leaps + month_offset[m] + d;
        if (m > 2 && leap(y))
            day_number = day_number + 1;
    endfunction

    // Distance between the two dates and weekday of the first one
    function automatic dd_pkg::t_out reckon_dates(input dd_pkg::t_in dates);
        dd_pkg::t_out r;
        longint       s1;
        longint       s2;
        longint       span;
        longint       rem;
        r = '0;
        if (!month_ok(dates.first_month) || !month_ok(dates.second_month)) begin
            r.month_error = 1'b1;
            return r;
        end
        s1 = day_number(dates.first_year, dates.first_month, dates.first_day);
        s2 = day_number(dates.second_year, dates.second_month, dates.second_day);
        span = (s1 > s2) ? s1 - s2 : s2 - s1;
        if (span > SPAN_CEILING)
            span = SPAN_CEILING;
        r.day_distance = dd_pkg::DIST_W'(span);
        // fold negative offsets so dates before the epoch count backwards
        rem = (s1 - day_number(EPOCH_Y, 1, 1)) % 7;
        if (rem < 0)
            rem = rem + 7;
        r.weekday = 3'((rem + THURSDAY) % 7);
        return r;
    endfunction

    task automatic report(input string field, input longint want, input longint got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        fails++;
    endtask

    // Result transfers are retired before command transfers of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with none expected: distance %0d weekday %0d error %0d",
                             $time, o_result.day_distance, o_result.weekday,
                             o_result.month_error);
                    fails++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (o_result.day_distance !== oldest.day_distance)
                        report("day_distance", oldest.day_distance, o_result.day_distance);
                    if (o_result.weekday !== oldest.weekday)
                        report("weekday", oldest.weekday, o_result.weekday);
                    if (o_result.month_error !== oldest.month_error)
                        report("month_error", oldest.month_error, o_result.month_error);
                end
            end
            if (start && !busy)
                awaited_results.push_back(reckon_dates(i_item));
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/tb_date_difference_and_weekday_unit.sv =====
`timescale 1ns / 100ps

module tb_date_difference_and_weekday_unit;

    localparam int ITEM_COUNT  = 1800;
    localparam int CALM_TAIL   = 300;
    localparam int DRAIN_POINT = 900;
    localparam int SEGMENT     = 40;
    localparam int STALL_LIMIT = 1000;

    logic         i_clk   = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    logic         busy;
    dd_pkg::t_in  i_item  = '0;
    logic         o_valid;
    dd_pkg::t_out o_result;
    int unsigned  fail_count;
    int unsigned  pending;
    int           idle_cycles;
    bit           gaps_on;

    always #4 i_clk = ~i_clk;

    date_difference_and_weekday_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    date_span_checker span_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_valid      (o_valid),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic dd_pkg::t_in pack_dates(input int y1, input int m1, input int d1,
                                               input int y2, input int m2, input int d2);
        dd_pkg::t_in p;
        p.first_year   = dd_pkg::YEAR_W'(y1);
        p.first_month  = dd_pkg::MONTH_W'(m1);
        p.first_day    = dd_pkg::DAY_W'(d1);
        p.second_year  = dd_pkg::YEAR_W'(y2);
        p.second_month = dd_pkg::MONTH_W'(m2);
        p.second_day   = dd_pkg::DAY_W'(d2);
        return p;
    endfunction

    // Mostly well-formed dates, with leap-rule, epoch and error cases mixed in
    function automatic dd_pkg::t_in random_dates();
        dd_pkg::t_in p;
        int unsigned kind;
        int unsigned y;
        int unsigned bad;
        kind = $urandom_range(0, 99);
        p = pack_dates($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31),
                       $urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
        if (kind < 20) begin
            // nearby dates
            y = $urandom_range(1, 9998);
            p.first_year  = dd_pkg::YEAR_W'(y);
            p.second_year = dd_pkg::YEAR_W'(y + $urandom_range(0, 1));
        end else if (kind < 35) begin
            // around the epoch
            p.first_year  = dd_pkg::YEAR_W'($urandom_range(1960, 1980));
            p.second_year = dd_pkg::YEAR_W'($urandom_range(1960, 1980));
        end else if (kind < 48) begin
            // century and leap years across the February boundary
            p.first_year   = dd_pkg::YEAR_W'(100 * $urandom_range(0, 99));
            p.second_year  = dd_pkg::YEAR_W'(4 * $urandom_range(0, 2499));
            p.first_month  = dd_pkg::MONTH_W'($urandom_range(2, 3));
            p.second_month = dd_pkg::MONTH_W'($urandom_range(2, 3));
        end else if (kind < 62) begin
            // whole year and day field range, day 0 and years past 9999 included
            p = pack_dates($urandom_range(0, 16383), $urandom_range(1, 12),
                           $urandom_range(0, 31), $urandom_range(0, 16383),
                           $urandom_range(1, 12), $urandom_range(0, 31));
        end else if (kind < 72) begin
            // month out of range on one or both dates
            bad = $urandom_range(0, 3);
            bad = (bad == 0) ? 0 : bad + 12;
            if (kind < 66)
                p.first_month = dd_pkg::MONTH_W'(bad);
            else if (kind < 70)
                p.second_month = dd_pkg::MONTH_W'(bad);
            else begin
                p.first_month  = dd_pkg::MONTH_W'(bad);
                p.second_month = dd_pkg::MONTH_W'($urandom_range(0, 1) ? 0 :
                                                  $urandom_range(13, 15));
            end
            p.first_year  = dd_pkg::YEAR_W'($urandom_range(0, 16383));
            p.second_year = dd_pkg::YEAR_W'($urandom_range(0, 16383));
        end
        return p;
    endfunction

    // Hold start high until a command transfer takes place
    task automatic issue(input dd_pkg::t_in dates);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= dates;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Stall watchdog: ends the run when no transfer happens for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("date_difference_and_weekday_unit: mismatch");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: epoch, leap rules, extremes, unchecked days, bad months
        issue(pack_dates(1970, 1, 1, 1970, 1, 1));
        issue(pack_dates(1969, 12, 31, 1970, 1, 1));
        issue(pack_dates(1, 1, 1, 9999, 12, 31));
        issue(pack_dates(9999, 12, 31, 1, 1, 1));
        issue(pack_dates(2000, 2, 29, 1900, 2, 28));
        issue(pack_dates(1900, 3, 1, 1900, 2, 29));
        issue(pack_dates(2024, 3, 1, 2024, 2, 29));
        issue(pack_dates(2100, 3, 1, 2100, 2, 28));
        issue(pack_dates(2023, 4, 31, 2023, 5, 1));
        issue(pack_dates(1970, 1, 0, 1970, 1, 31));
        issue(pack_dates(0, 3, 1, 0, 2, 29));
        issue(pack_dates(0, 1, 0, 1, 1, 1));
        issue(pack_dates(16383, 12, 31, 0, 1, 0));
        issue(pack_dates(16383, 1, 1, 10000, 1, 1));
        issue(pack_dates(16383, 12, 31, 16383, 1, 0));
        issue(pack_dates(1600, 12, 31, 1601, 1, 1));
        issue(pack_dates(1582, 10, 15, 1970, 1, 1));
        issue(pack_dates(2000, 0, 15, 2000, 1, 1));
        issue(pack_dates(2000, 1, 1, 2000, 13, 1));
        issue(pack_dates(16383, 15, 31, 16383, 15, 31));
        issue(pack_dates(0, 0, 0, 0, 0, 0));
        issue(pack_dates(1999, 14, 9, 2001, 12, 31));

        // Random traffic with bursty gaps, then a gap-free tail
        gaps_on = 1'b1;
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % SEGMENT == 0)
                gaps_on = $urandom_range(0, 1);
            if (n == DRAIN_POINT) begin
                // let every outstanding result arrive before going on
                @(negedge i_clk);
                start <= 1'b0;
                while (pending != 0)
                    @(negedge i_clk);
            end
            if (n < ITEM_COUNT - CALM_TAIL && gaps_on && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 18));
            issue(random_dates());
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (dd_pkg::LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("date_difference_and_weekday_unit: match");
        else
            $display("date_difference_and_weekday_unit: mismatch");
        $finish;
    end

endmodule
